### rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/bfnb_pkg.sv
package bfnb_pkg;

    localparam int MODE_W  = 2;
    localparam int INDEX_W = 6;
    localparam int DATA_W  = 64;
    localparam int START_W = 12;
    localparam int SIZE_W  = 13;

    localparam logic [MODE_W-1:0] MODE_WRITE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FIND_ZERO = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FIND_ONE  = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [INDEX_W-1:0] word_index;
        logic [DATA_W-1:0]  word_data;
        logic [START_W-1:0] start_bit;
    } cmd_t;

    typedef struct packed {
        logic [SIZE_W-1:0] bit_index;
        logic              none_found;
    } result_t;

endpackage

### rtl/bitmap_find_next_bit_core.sv
// channel   | direction | handshake                     | beat
// ----------+-----------+-------------------------------+---------------------------
// command   | in        | start high while busy low     | cmd (mode, index, data, start)
// config    | in        | cfg_valid and cfg_ready high  | cfg_data, bitmap size
// result    | out       | result_strobe, one cycle      | result (bit_index, none_found)
//
// a word write goes straight to the ram, leaves busy low and gives no result beat
// a search goes through the prep, split and scan states, and the scan state checks one
// ram word per cycle, from the word holding the start bit up to the bitmap size
// a start at or past the size is answered from the prep state without reading the ram
// after reset a clearing pass zeroes every ram word with busy high
// the result beat shows in the cycle after the search ends and cannot be held off
`include "assert_macros.svh"

module bitmap_find_next_bit_core #(
    parameter int WORD_BITS = 64,
    parameter int MAP_WORDS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  bfnb_pkg::cmd_t                cmd,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bfnb_pkg::SIZE_W-1:0]   cfg_data,
    output bfnb_pkg::result_t             result,
    output logic                          result_strobe
);

    import bfnb_pkg::*;

    localparam int AW      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int IDX_W   = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int POS_W   = SIZE_W + 1;
    localparam int CAP     = MAP_WORDS * WORD_BITS;
    localparam int SH      = START_W + IDX_W;
    localparam int RECIP   = ((2 ** SH) + WORD_BITS - 1) / WORD_BITS;
    localparam int PROD_W  = START_W + SH + 1;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_PREP  = 5'b00100,
        ST_SPLIT = 5'b01000,
        ST_SCAN  = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    logic [AW-1:0]         clr_reg, clr_next;
    logic [SIZE_W-1:0]     bitmap_size_reg, bitmap_size_next;
    logic                  strobe_reg, strobe_next;

    logic [START_W-1:0]    start_reg, start_next;
    logic [SIZE_W-1:0]     size_reg, size_next;
    logic                  want_one_reg, want_one_next;
    logic [AW-1:0]         q_reg, q_next;
    logic [AW-1:0]         w_reg, w_next;
    logic [POS_W-1:0]      base_reg, base_next;
    logic [WORD_BITS-1:0]  mask_reg, mask_next;
    result_t               result_reg, result_next;

    logic                  accept;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [WORD_BITS-1:0]  ram_rdata;
    logic                  scan_hit;
    logic [IDX_W-1:0]      scan_idx;
    logic [PROD_W-1:0]     prod;
    logic [POS_W-1:0]      split_base;
    logic [POS_W-1:0]      pos;
    logic [POS_W-1:0]      next_base;

    assign busy          = (state_reg != ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign accept        = start && !busy;
    assign result        = result_reg;
    assign result_strobe = strobe_reg;

    bfnb_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bfnb_scan #(
        .WORD_BITS (WORD_BITS)
    ) u_scan (
        .word     (ram_rdata),
        .mask     (mask_reg),
        .want_one (want_one_reg),
        .hit      (scan_hit),
        .idx      (scan_idx)
    );

    // ram write port: clearing pass or a word write beat
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = accept && (cmd.mode == MODE_WRITE)
                        && (int'(cmd.word_index) < MAP_WORDS);
            ram_waddr = AW'(cmd.word_index);
            ram_wdata = cmd.word_data[WORD_BITS-1:0];
        end
        ram_raddr = (state_reg == ST_SPLIT) ? q_reg : AW'(w_reg + 1'b1);
    end

    // start / WORD_BITS by reciprocal multiply, exact over the start range
    assign prod       = PROD_W'(start_reg) * PROD_W'(RECIP);
    assign split_base = POS_W'(q_reg) * POS_W'(WORD_BITS);
    assign pos        = base_reg + POS_W'(scan_idx);
    assign next_base  = base_reg + POS_W'(WORD_BITS);

    always_comb
    begin
        state_next       = state_reg;
        clr_next         = clr_reg;
        bitmap_size_next = bitmap_size_reg;
        strobe_next      = 1'b0;
        start_next       = start_reg;
        size_next        = size_reg;
        want_one_next    = want_one_reg;
        q_next           = q_reg;
        w_next           = w_reg;
        base_next        = base_reg;
        mask_next        = mask_reg;
        result_next      = result_reg;

        if (cfg_valid && cfg_ready)
        begin
            bitmap_size_next = cfg_data;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = AW'(clr_reg + 1'b1);
                if (int'(clr_reg) == MAP_WORDS - 1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && (cmd.mode == MODE_FIND_ZERO || cmd.mode == MODE_FIND_ONE))
                begin
                    start_next    = cmd.start_bit;
                    want_one_next = (cmd.mode == MODE_FIND_ONE);
                    size_next     = (int'(bitmap_size_reg) < CAP) ? bitmap_size_reg
                                                                  : SIZE_W'(CAP);
                    state_next    = ST_PREP;
                end
            end
            ST_PREP:
            begin
                q_next = AW'(prod >> SH);
                if (SIZE_W'(start_reg) >= size_reg)
                begin
                    result_next.bit_index  = size_reg;
                    result_next.none_found = 1'b1;
                    strobe_next            = 1'b1;
                    state_next             = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SPLIT;
                end
            end
            ST_SPLIT:
            begin
                // first word read issued here, low bits below start masked off
                w_next     = q_reg;
                base_next  = split_base;
                mask_next  = {WORD_BITS{1'b1}} << IDX_W'(POS_W'(start_reg) - split_base);
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_hit)
                begin
                    if (pos < POS_W'(size_reg))
                    begin
                        result_next.bit_index  = SIZE_W'(pos);
                        result_next.none_found = 1'b0;
                    end
                    else
                    begin
                        result_next.bit_index  = size_reg;
                        result_next.none_found = 1'b1;
                    end
                    strobe_next = 1'b1;
                    state_next  = ST_IDLE;
                end
                else if (next_base >= POS_W'(size_reg))
                begin
                    result_next.bit_index  = size_reg;
                    result_next.none_found = 1'b1;
                    strobe_next            = 1'b1;
                    state_next             = ST_IDLE;
                end
                else
                begin
                    w_next    = AW'(w_reg + 1'b1);
                    base_next = next_base;
                    mask_next = {WORD_BITS{1'b1}};
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_reg         <= '0;
            bitmap_size_reg <= SIZE_RESET;
            strobe_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_reg         <= clr_next;
            bitmap_size_reg <= bitmap_size_next;
            strobe_reg      <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg    <= start_next;
        size_reg     <= size_next;
        want_one_reg <= want_one_next;
        q_reg        <= q_next;
        w_reg        <= w_next;
        base_reg     <= base_next;
        mask_reg     <= mask_next;
        result_reg   <= result_next;
    end

    `ASSERT_IMPLY(a_none_flag, clk, rst_n, strobe_reg,
        result_reg.none_found == (result_reg.bit_index == size_reg),
        "none_found disagrees with bit_index against size")
    `ASSERT_IMPLY(a_index_bound, clk, rst_n, strobe_reg,
        result_reg.bit_index <= size_reg, "bit_index beyond bitmap size")
    `ASSERT_IMPLY(a_scan_in_range, clk, rst_n, state_reg == ST_SCAN,
        base_reg < POS_W'(size_reg), "scanning a word past the bitmap size")
    `ASSERT_NEXT(a_search_busy, clk, rst_n,
        accept && (cmd.mode == MODE_FIND_ZERO || cmd.mode == MODE_FIND_ONE),
        busy && !strobe_reg, "search beat did not start the sequencer")

endmodule

### rtl/bfnb_ram.sv
module bfnb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/bfnb_scan.sv
module bfnb_scan #(
    parameter int WORD_BITS = 64,
    localparam int IDX_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1
) (
    input  logic [WORD_BITS-1:0] word,
    input  logic [WORD_BITS-1:0] mask,
    input  logic                 want_one,
    output logic                 hit,
    output logic [IDX_W-1:0]     idx
);

    logic [WORD_BITS-1:0] cand;
    logic [WORD_BITS-1:0] lowest;

    always_comb
    begin
        cand   = (want_one ? word : ~word) & mask;
        // isolate the lowest set bit, then encode its one-hot position
        lowest = cand & (~cand + WORD_BITS'(1));
        hit    = |cand;
        idx    = '0;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            idx = idx | (lowest[j] ? IDX_W'(j) : '0);
        end
    end

endmodule

### tb/tb_bitmap_find_next_bit_core.sv
module tb_bitmap_find_next_bit_core;
    import bfnb_pkg::*;

    localparam int WORD_BITS = 64;
    localparam int MAP_WORDS = 64;
    localparam int CAPACITY = WORD_BITS * MAP_WORDS;
    localparam int STALL_LIMIT = 1000;
    localparam int RAND_ITEMS = 852;
    localparam int PHASES = 6;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        bit               is_cfg;
        logic [SIZE_W-1:0] size_val;
        cmd_t             c;
        bit               typed;
        result_t          want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    cmd_t cmd;
    logic cfg_valid;
    logic cfg_ready;
    logic [SIZE_W-1:0] cfg_data;
    result_t result;
    logic result_strobe;

    // shadow copy of the block state
    logic [WORD_BITS-1:0] shadow_map [MAP_WORDS];
    logic [SIZE_W-1:0] shadow_size;

    result_t pending_hits[$];
    stim_row_t stim_rows[$];
    int errors;
    int idle_cycles;
    int n_search;
    int n_write;
    int n_ignored;
    int n_sizes;
    bit no_gaps;

    bitmap_find_next_bit_core #(
        .WORD_BITS(WORD_BITS),
        .MAP_WORDS(MAP_WORDS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .result(result),
        .result_strobe(result_strobe)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int map_limit();
        return (shadow_size > CAPACITY) ? CAPACITY : int'(shadow_size);
    endfunction

    // lowest bit at or above from that equals want_one, clamped to the size in use
    function automatic result_t next_bit(logic want_one, logic [START_W-1:0] from);
        result_t r;
        int lim;
        bit hit;
        lim = map_limit();
        r.bit_index = SIZE_W'(lim);
        r.none_found = 1'b1;
        hit = 1'b0;
        for (int b = int'(from); b < lim; b++)
        begin
            if (!hit && shadow_map[b / WORD_BITS][b % WORD_BITS] == want_one)
            begin
                hit = 1'b1;
                r.bit_index = SIZE_W'(b);
                r.none_found = 1'b0;
            end
        end
        return r;
    endfunction

    task automatic add_cmd(input logic [MODE_W-1:0] mode, input logic [INDEX_W-1:0] idx,
                           input logic [DATA_W-1:0] data, input logic [START_W-1:0] from,
                           input bit typed, input int bi, input bit nf);
        stim_row_t row;
        row.is_cfg = 1'b0;
        row.size_val = '0;
        row.c.mode = mode;
        row.c.word_index = idx;
        row.c.word_data = data;
        row.c.start_bit = from;
        row.typed = typed;
        row.want.bit_index = SIZE_W'(bi);
        row.want.none_found = nf;
        stim_rows.push_back(row);
    endtask

    task automatic add_cfg(input logic [SIZE_W-1:0] v);
        stim_row_t row;
        row.is_cfg = 1'b1;
        row.size_val = v;
        row.c = '0;
        row.typed = 1'b0;
        row.want = '0;
        stim_rows.push_back(row);
    endtask

    // called at a falling edge, raises start and returns at a falling edge without lowering it
    task automatic send_cmd(input cmd_t c, input bit typed, input result_t want);
        result_t r;
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        case (c.mode)
            MODE_WRITE:
            begin
                shadow_map[c.word_index] = c.word_data;
                n_write++;
            end
            MODE_FIND_ZERO, MODE_FIND_ONE:
            begin
                r = typed ? want : next_bit(c.mode == MODE_FIND_ONE, c.start_bit);
                pending_hits.push_back(r);
                n_search++;
            end
            default:
                n_ignored++;
        endcase
        @(negedge clk);
    endtask

    // hold off until every search has answered and a trailing search has had time to end
    task automatic drain();
        start <= 1'b0;
        while (pending_hits.size() != 0)
            @(negedge clk);
        repeat (MAP_WORDS + 4) @(negedge clk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        shadow_size = v;
        n_sizes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
        begin
            if (pending_hits.size() == 0)
            begin
                $error("result beat with no search outstanding: bit_index %0d none_found %0d",
                       result.bit_index, result.none_found);
                errors++;
            end
            else
            begin
                result_t want;
                want = pending_hits.pop_front();
                if (result.bit_index !== want.bit_index)
                begin
                    $error("bit_index: expected %0d, got %0d", want.bit_index, result.bit_index);
                    errors++;
                end
                if (result.none_found !== want.none_found)
                begin
                    $error("none_found: expected %0d, got %0d", want.none_found,
                           result.none_found);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || (cfg_valid && cfg_ready) || result_strobe)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        cmd_t c;
        result_t none;
        logic [SIZE_W-1:0] phase_size;
        int lim;
        int per_phase;
        int item;

        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        n_search = 0;
        n_write = 0;
        n_ignored = 0;
        n_sizes = 0;
        no_gaps = 1'b0;
        none = '0;
        for (int i = 0; i < MAP_WORDS; i++)
            shadow_map[i] = '0;
        shadow_size = SIZE_RESET;

        // empty map after reset, then ends of the map, ignored mode, size extremes
        add_cmd(MODE_FIND_ZERO, 0, '0, 0, 1, 0, 0);
        add_cmd(MODE_FIND_ONE, 0, '0, 0, 1, 4096, 1);
        add_cmd(MODE_FIND_ONE, 0, '0, 4095, 1, 4096, 1);
        add_cmd(MODE_FIND_ZERO, 0, '0, 4095, 1, 4095, 0);
        add_cmd(MODE_WRITE, 0, '1, 0, 0, 0, 0);
        add_cmd(MODE_FIND_ZERO, 0, '0, 0, 1, 64, 0);
        add_cmd(MODE_WRITE, 63, 64'h8000_0000_0000_0000, 0, 0, 0, 0);
        add_cmd(MODE_FIND_ONE, 0, '0, 1, 1, 1, 0);
        add_cmd(MODE_FIND_ONE, 0, '0, 64, 1, 4095, 0);
        add_cmd(MODE_UNUSED, 7, '1, 0, 0, 0, 0);
        add_cmd(MODE_FIND_ONE, 0, '0, 64, 1, 4095, 0);
        add_cmd(MODE_WRITE, 63, '1, 0, 0, 0, 0);
        add_cmd(MODE_FIND_ZERO, 0, '0, 4032, 1, 4096, 1);
        add_cmd(MODE_WRITE, 31, 64'hAAAA_AAAA_AAAA_AAAA, 0, 0, 0, 0);
        add_cmd(MODE_FIND_ONE, 0, '0, 1985, 0, 0, 0);
        add_cmd(MODE_FIND_ZERO, 0, '0, 1985, 0, 0, 0);
        add_cfg(0);
        add_cmd(MODE_FIND_ZERO, 0, '0, 0, 1, 0, 1);
        add_cmd(MODE_FIND_ONE, 0, '0, 4095, 1, 0, 1);
        add_cfg(1);
        add_cmd(MODE_FIND_ONE, 0, '0, 0, 1, 0, 0);
        add_cmd(MODE_FIND_ZERO, 0, '0, 0, 1, 1, 1);
        add_cfg(8191);
        add_cmd(MODE_FIND_ZERO, 0, '0, 4032, 1, 4096, 1);
        add_cfg(100);
        add_cmd(MODE_FIND_ONE, 0, '0, 70, 0, 0, 0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].is_cfg)
                write_size(stim_rows[i].size_val);
            else
                send_cmd(stim_rows[i].c, stim_rows[i].typed, stim_rows[i].want);
        end

        per_phase = RAND_ITEMS / PHASES;
        item = 0;
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: phase_size = SIZE_RESET;
                1: phase_size = SIZE_W'($urandom_range(1, 4096));
                2: phase_size = 13'd8191;
                3: phase_size = SIZE_W'($urandom_range(1, 200));
                4: phase_size = 13'd1;
                default: phase_size = SIZE_W'($urandom_range(0, 8191));
            endcase
            write_size(phase_size);
            lim = map_limit();
            // one phase runs back to back
            no_gaps = (p == 1);
            for (int k = 0; k < per_phase; k++)
            begin
                c.word_index = INDEX_W'($urandom);
                c.start_bit = START_W'($urandom);
                c.word_data = {$urandom, $urandom};
                case ($urandom_range(0, 19))
                    0: c.mode = MODE_UNUSED;
                    1, 2, 3, 4, 5, 6, 7: c.mode = MODE_WRITE;
                    default: c.mode = ($urandom_range(0, 1) != 0) ? MODE_FIND_ONE
                                                                  : MODE_FIND_ZERO;
                endcase
                // mostly full or empty words so searches walk many words
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: c.word_data = '1;
                    4, 5: c.word_data = '0;
                    6: c.word_data = DATA_W'(1) << $urandom_range(0, DATA_W - 1);
                    7: c.word_data = ~(DATA_W'(1) << $urandom_range(0, DATA_W - 1));
                    default: ;
                endcase
                if (lim > 0 && $urandom_range(0, 9) < 7)
                    c.start_bit = START_W'($urandom_range(0, lim - 1));
                if (!no_gaps)
                begin
                    while ($urandom_range(0, 99) < 11)
                    begin
                        start <= 1'b0;
                        @(negedge clk);
                    end
                end
                send_cmd(c, 1'b0, none);
                item++;
            end
        end

        start <= 1'b0;
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (MAP_WORDS + 8) @(posedge clk);

        $display("run covered %0d searches, %0d word writes and %0d ignored commands",
                 n_search, n_write, n_ignored);
        $display("across %0d bitmap size settings, from empty up to above the capacity",
                 n_sizes);
        if (errors == 0 && pending_hits.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### bitmap_find_next_bit_core.f
+incdir+rtl
rtl/bfnb_pkg.sv
rtl/bfnb_ram.sv
rtl/bfnb_scan.sv
rtl/bitmap_find_next_bit_core.sv
tb/tb_bitmap_find_next_bit_core.sv
